### hw/rtl/lzhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzhc_pkg
// Shared types, constants and helper functions of the LZSS hash-chain match
// finder.
// ----------------------------------------------------------------------------
package lzhc_pkg;

    localparam int WINDOW        = 4096;
    localparam int POS_W         = $clog2(WINDOW);
    localparam int HASH_BITS     = 14;
    localparam int HEAD_COUNT    = 1 << HASH_BITS;
    localparam int CN_DEPTH      = WINDOW + HEAD_COUNT;
    localparam int CN_AW         = $clog2(CN_DEPTH);
    localparam int LINK_W        = $clog2(CN_DEPTH + 1);
    localparam int MAX_LEN_LIMIT = 255;
    localparam int RUN_MAX       = 255;

    // chain_next holds positions below WINDOW and chain heads at and above it
    localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(CN_DEPTH);
    localparam logic [LINK_W-1:0] HEAD_BASE = LINK_W'(WINDOW);

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PRIME   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_SEARCH  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CLEAR,
        OP_UL_RD, OP_UL_CHK, OP_UL_WUP, OP_UL_WP,
        OP_ADV_WR,
        OP_HS0, OP_HS1, OP_HS2, OP_HS3, OP_HS4,
        OP_LK_RD, OP_LK_W1, OP_LK_W2,
        OP_SR_INIT, OP_SR_RD, OP_SR_NEXT, OP_CMP_RD, OP_CMP_EQ, OP_EVAL,
        OP_RN_START, OP_RN_N, OP_RN_RD, OP_RN_CMP, OP_RN_FIN,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR,
        ST_UL_RD, ST_UL_CHK, ST_UL_WUP, ST_UL_WP,
        ST_ADV_WR,
        ST_HS0, ST_HS1, ST_HS2, ST_HS3, ST_HS4,
        ST_LK_RD, ST_LK_W1, ST_LK_W2,
        ST_SR_INIT, ST_SR_RD, ST_SR_NEXT, ST_CMP_RD, ST_CMP_EQ, ST_EVAL,
        ST_RN_START, ST_RN_N, ST_RN_RD, ST_RN_CMP, ST_RN_FIN,
        ST_OUT
    } ctl_state_t;

    // what the unlink and hash sequences return to
    typedef enum logic [1:0] {
        CTX_ADV_OLD,
        CTX_ADV_LINK,
        CTX_SEARCH
    } ctx_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic ul_null;
        logic nx_null;
        logic nx_self;
        logic cmp_eq;
        logic k_lt4;
        logic len_done;
        logic ev_take;
        logic ev_full;
        logic pm_zero;
        logic rn_go;
        logic rn_eq;
        logic n_is1;
        logic j_last;
        logic out_free;
        logic flag;
    } dp_stat_t;

    function automatic logic [7:0] eff_len(input logic [7:0] ml);
        logic [8:0] v;
        begin
            v = {1'b0, ml};
            if (v < 9'd4) v = 9'd4;
            if (v > 9'(MAX_LEN_LIMIT)) v = 9'(MAX_LEN_LIMIT);
            if (WINDOW < 2 * int'(v)) v = 9'(WINDOW / 2 - 1);
            return v[7:0];
        end
    endfunction

    localparam logic [7:0] EFF_RST = eff_len(8'd255);

    function automatic logic [HASH_BITS-1:0] hash4(input logic [7:0] b0,
                                                   input logic [7:0] b1,
                                                   input logic [7:0] b2,
                                                   input logic [7:0] b3);
        logic [15:0] h;
        begin
            h = {8'd0, b0} ^ ({8'd0, b1} << 2) ^ ({8'd0, b2} << 4) ^ ({8'd0, b3} << 6);
            return h[HASH_BITS-1:0];
        end
    endfunction

    // length / period for periods 1..4; divide by 3 via reciprocal 171/512
    function automatic logic [7:0] run_div(input logic [7:0] p, input logic [2:0] per);
        logic [16:0] prod;
        logic [7:0]  q;
        begin
            prod = 17'(p) * 17'd171;
            case (per)
                3'd2:    q = p >> 1;
                3'd3:    q = prod[16:9];
                3'd4:    q = p >> 2;
                default: q = p;
            endcase
            return q;
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/lzhc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzhc_ctrl
// Sequencer of the match finder: clear pass, chain unlink/link, chain walk,
// byte compares and run detection.
// ----------------------------------------------------------------------------
module lzhc_ctrl
    import lzhc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    input  wire cmd_t     in_cmd,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctl_state_t state_reg, state_next;
    ctx_t       ctx_reg, ctx_next;
    ctl_state_t ret_st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ctx_reg   <= CTX_SEARCH;
        end else begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    always_comb begin
        case (ctx_reg)
            CTX_ADV_OLD:  ret_st = ST_ADV_WR;
            CTX_ADV_LINK: ret_st = ST_HS0;
            default:      ret_st = ST_RN_START;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_cmd)
                        CMD_CLEAR:   state_next = ST_CLEAR;
                        CMD_ADVANCE: begin
                            state_next = ST_UL_RD;
                            ctx_next   = CTX_ADV_OLD;
                        end
                        CMD_SEARCH: begin
                            state_next = ST_HS0;
                            ctx_next   = CTX_SEARCH;
                        end
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:  if (stat.clr_last) state_next = ST_IDLE;
            ST_UL_RD:  state_next = ST_UL_CHK;
            ST_UL_CHK: state_next = stat.ul_null ? ret_st : ST_UL_WUP;
            ST_UL_WUP: state_next = ST_UL_WP;
            ST_UL_WP:  state_next = ret_st;
            ST_ADV_WR: begin
                if (stat.flag) begin
                    state_next = ST_UL_RD;
                    ctx_next   = CTX_ADV_LINK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HS0:    state_next = ST_HS1;
            ST_HS1:    state_next = ST_HS2;
            ST_HS2:    state_next = ST_HS3;
            ST_HS3:    state_next = ST_HS4;
            ST_HS4:    state_next = (ctx_reg == CTX_SEARCH) ? ST_SR_INIT : ST_LK_RD;
            ST_LK_RD:  state_next = ST_LK_W1;
            ST_LK_W1:  state_next = ST_LK_W2;
            ST_LK_W2:  state_next = ST_IDLE;
            ST_SR_INIT: state_next = ST_SR_RD;
            ST_SR_RD:   state_next = ST_SR_NEXT;
            ST_SR_NEXT: begin
                if (stat.nx_null)      state_next = ST_RN_START;
                else if (stat.nx_self) state_next = ST_SR_RD;
                else                   state_next = ST_CMP_RD;
            end
            ST_CMP_RD: state_next = ST_CMP_EQ;
            ST_CMP_EQ: begin
                if (!stat.cmp_eq)       state_next = stat.k_lt4 ? ST_SR_RD : ST_EVAL;
                else if (stat.len_done) state_next = ST_EVAL;
                else                    state_next = ST_CMP_RD;
            end
            ST_EVAL: begin
                if (stat.ev_take && stat.ev_full) begin
                    state_next = ST_UL_RD;
                    ctx_next   = CTX_SEARCH;
                end else begin
                    state_next = ST_SR_RD;
                end
            end
            ST_RN_START: state_next = stat.pm_zero ? ST_RN_FIN : ST_RN_N;
            ST_RN_N: begin
                if (stat.rn_go)      state_next = ST_RN_RD;
                else if (stat.n_is1) state_next = ST_RN_FIN;
                else                 state_next = ST_RN_N;
            end
            ST_RN_RD:  state_next = ST_RN_CMP;
            ST_RN_CMP: begin
                if (!stat.rn_eq)      state_next = stat.n_is1 ? ST_RN_FIN : ST_RN_N;
                else if (stat.j_last) state_next = ST_RN_N;
                else                  state_next = ST_RN_RD;
            end
            ST_RN_FIN: state_next = ST_OUT;
            ST_OUT:    if (stat.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_CLEAR:    cmd.op = OP_CLEAR;
            ST_UL_RD:    cmd.op = OP_UL_RD;
            ST_UL_CHK:   cmd.op = OP_UL_CHK;
            ST_UL_WUP:   cmd.op = OP_UL_WUP;
            ST_UL_WP:    cmd.op = OP_UL_WP;
            ST_ADV_WR:   cmd.op = OP_ADV_WR;
            ST_HS0:      cmd.op = OP_HS0;
            ST_HS1:      cmd.op = OP_HS1;
            ST_HS2:      cmd.op = OP_HS2;
            ST_HS3:      cmd.op = OP_HS3;
            ST_HS4:      cmd.op = OP_HS4;
            ST_LK_RD:    cmd.op = OP_LK_RD;
            ST_LK_W1:    cmd.op = OP_LK_W1;
            ST_LK_W2:    cmd.op = OP_LK_W2;
            ST_SR_INIT:  cmd.op = OP_SR_INIT;
            ST_SR_RD:    cmd.op = OP_SR_RD;
            ST_SR_NEXT:  cmd.op = OP_SR_NEXT;
            ST_CMP_RD:   cmd.op = OP_CMP_RD;
            ST_CMP_EQ:   cmd.op = OP_CMP_EQ;
            ST_EVAL:     cmd.op = OP_EVAL;
            ST_RN_START: cmd.op = OP_RN_START;
            ST_RN_N:     cmd.op = OP_RN_N;
            ST_RN_RD:    cmd.op = OP_RN_RD;
            ST_RN_CMP:   cmd.op = OP_RN_CMP;
            ST_RN_FIN:   cmd.op = OP_RN_FIN;
            ST_OUT:      cmd.op = OP_OUT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

### hw/rtl/lzhc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzhc_dp
// Datapath: history ring, chain link memories, pointers, compare and run
// logic, output register.
// ----------------------------------------------------------------------------
module lzhc_dp
    import lzhc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire dp_cmd_t     cmd,
    input  wire cmd_t        in_cmd,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_flag,
    input  wire logic [7:0]  eff,
    output dp_stat_t         stat,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [39:0]      m_data
);

    // memories
    logic [7:0]        ring_mem [WINDOW];
    logic [LINK_W-1:0] cn_mem   [CN_DEPTH];
    logic [LINK_W-1:0] cp_mem   [WINDOW];

    logic              ring_we;
    logic [POS_W-1:0]  ring_waddr, ra_addr, rb_addr;
    logic [7:0]        ring_wdata, ra_reg, rb_reg;
    logic              cn_we;
    logic [CN_AW-1:0]  cn_waddr, cn_raddr;
    logic [LINK_W-1:0] cn_wdata, cn_q_reg;
    logic              cp_we;
    logic [POS_W-1:0]  cp_waddr, cp_raddr;
    logic [LINK_W-1:0] cp_wdata, cp_q_reg;

    always_ff @(posedge aclk) begin
        if (ring_we) ring_mem[ring_waddr] <= ring_wdata;
        ra_reg <= ring_mem[ra_addr];
        rb_reg <= ring_mem[rb_addr];
    end

    always_ff @(posedge aclk) begin
        if (cn_we) cn_mem[cn_waddr] <= cn_wdata;
        cn_q_reg <= cn_mem[cn_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cp_we) cp_mem[cp_waddr] <= cp_wdata;
        cp_q_reg <= cp_mem[cp_raddr];
    end

    // registers
    logic [POS_W-1:0]  cur_reg, cur_next, old_reg, old_next, p_reg, p_next;
    logic [7:0]        prime_reg, prime_next;
    logic [CN_AW-1:0]  clr_reg, clr_next;
    logic [LINK_W-1:0] up_reg, up_next, dn_reg, dn_next;
    logic [LINK_W-1:0] node_reg, node_next, head_reg, head_next;
    logic [7:0]        data_reg, data_next;
    logic              flag_reg, flag_next;
    logic [7:0]        b_reg [8];
    logic [7:0]        b_next [8];
    logic [7:0]        k_reg, k_next, best_len_reg, best_len_next;
    logic [POS_W-1:0]  best_ofs_reg, best_ofs_next;
    logic [2:0]        pmax_reg, pmax_next, pmin_reg, pmin_next, n_reg, n_next;
    logic [1:0]        j_reg, j_next;
    logic [8:0]        rp_reg, rp_next;
    logic [7:0]        rlen_reg, rlen_next, rcnt_reg, rcnt_next;
    logic [2:0]        rper_reg, rper_next;
    logic              m_valid_reg, m_valid_next;
    logic [39:0]       m_data_reg, m_data_next;

    // derived values
    logic [8:0]       k1;
    logic             eq_ab, rn_eq;
    logic [POS_W-1:0] ofs, ev_len_w;
    logic [7:0]       ev_len;
    logic             ev_take;
    logic             eq1, eq2, eq3, eq4;
    logic [2:0]       pmax_c, pmin_c;
    logic [7:0]       rlim, rlen_c;
    logic             run_it;

    assign k1    = {1'b0, k_reg} + 9'd1;
    assign eq_ab = (ra_reg == rb_reg);
    assign rn_eq = (ra_reg == b_reg[j_reg]);
    assign ofs   = cur_reg - node_reg[POS_W-1:0];

    always_comb begin
        ev_take  = 1'b1;
        ev_len_w = POS_W'(k_reg);
        if (k_reg <= best_len_reg) begin
            ev_take = 1'b0;
        end else if (ofs < POS_W'(4)) begin
            ev_take = 1'b0;
        end else if (ofs <= POS_W'(k_reg)) begin
            // overlapping copy: clip to the offset
            if (ofs <= POS_W'(best_len_reg)) ev_take = 1'b0;
            else                             ev_len_w = ofs;
        end
        ev_len = ev_len_w[7:0];
    end

    assign eq1 = (b_reg[0] == b_reg[1]);
    assign eq2 = (b_reg[0] == b_reg[2]) && (b_reg[1] == b_reg[3]);
    assign eq3 = (b_reg[0] == b_reg[3]) && (b_reg[1] == b_reg[4]) && (b_reg[2] == b_reg[5]);
    assign eq4 = (b_reg[0] == b_reg[4]) && (b_reg[1] == b_reg[5]) &&
                 (b_reg[2] == b_reg[6]) && (b_reg[3] == b_reg[7]);
    assign pmax_c = eq4 ? 3'd4 : eq3 ? 3'd3 : eq2 ? 3'd2 : eq1 ? 3'd1 : 3'd0;
    assign pmin_c = eq1 ? 3'd1 : eq2 ? 3'd2 : eq3 ? 3'd3 : eq4 ? 3'd4 : 3'd0;
    assign rlim   = (eff < 8'(RUN_MAX)) ? eff : 8'(RUN_MAX);
    assign run_it = (n_reg == 3'd3) ? (pmax_reg == 3'd3 && pmin_reg == 3'd3)
                                    : (pmax_reg >= n_reg && pmin_reg <= n_reg);
    assign rlen_c = (rp_reg > {1'b0, rlim}) ? rlim : rp_reg[7:0];

    always_comb begin
        stat.clr_last = (clr_reg == CN_AW'(CN_DEPTH - 1));
        stat.ul_null  = (cp_q_reg >= LINK_NIL);
        stat.nx_null  = (cn_q_reg >= HEAD_BASE);
        stat.nx_self  = (cn_q_reg[POS_W-1:0] == cur_reg);
        stat.cmp_eq   = eq_ab;
        stat.k_lt4    = (k_reg < 8'd4);
        stat.len_done = eq_ab && (k1 >= 9'd4) && (k1 >= {1'b0, eff});
        stat.ev_take  = ev_take;
        stat.ev_full  = (ev_len >= eff);
        stat.pm_zero  = (pmin_c == 3'd0);
        stat.rn_go    = run_it && (({1'b0, rp_reg} + 10'(n_reg)) <= 10'(rlim));
        stat.rn_eq    = rn_eq;
        stat.n_is1    = (n_reg == 3'd1);
        stat.j_last   = (j_reg == 2'(n_reg - 3'd1));
        stat.out_free = !m_valid_reg || m_ready;
        stat.flag     = flag_reg;
    end

    always_comb begin
        cur_next      = cur_reg;
        old_next      = old_reg;
        p_next        = p_reg;
        prime_next    = prime_reg;
        clr_next      = clr_reg;
        up_next       = up_reg;
        dn_next       = dn_reg;
        node_next     = node_reg;
        head_next     = head_reg;
        data_next     = data_reg;
        flag_next     = flag_reg;
        b_next        = b_reg;
        k_next        = k_reg;
        best_len_next = best_len_reg;
        best_ofs_next = best_ofs_reg;
        pmax_next     = pmax_reg;
        pmin_next     = pmin_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        rp_next       = rp_reg;
        rlen_next     = rlen_reg;
        rper_next     = rper_reg;
        rcnt_next     = rcnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;

        ring_we    = 1'b0;
        ring_waddr = old_reg;
        ring_wdata = data_reg;
        ra_addr    = p_reg;
        rb_addr    = p_reg;
        cn_we      = 1'b0;
        cn_waddr   = clr_reg;
        cn_wdata   = LINK_NIL;
        cn_raddr   = node_reg[CN_AW-1:0];
        cp_we      = 1'b0;
        cp_waddr   = p_reg;
        cp_wdata   = LINK_NIL;
        cp_raddr   = p_reg;

        case (cmd.op)
            OP_ACCEPT: begin
                case (in_cmd)
                    CMD_CLEAR: begin
                        cur_next   = POS_W'(WINDOW - int'(eff));
                        old_next   = '0;
                        prime_next = '0;
                        clr_next   = '0;
                    end
                    CMD_PRIME: begin
                        if (prime_reg < eff) begin
                            ring_we    = 1'b1;
                            ring_waddr = cur_reg + POS_W'(prime_reg);
                            ring_wdata = in_byte;
                            prime_next = prime_reg + 8'd1;
                        end
                    end
                    CMD_ADVANCE: begin
                        data_next = in_byte;
                        flag_next = in_flag;
                        p_next    = old_reg;
                    end
                    default: p_next = cur_reg;
                endcase
            end
            OP_CLEAR: begin
                cn_we    = 1'b1;
                cn_waddr = clr_reg;
                cn_wdata = LINK_NIL;
                if (clr_reg < CN_AW'(WINDOW)) begin
                    cp_we    = 1'b1;
                    cp_waddr = clr_reg[POS_W-1:0];
                end
                clr_next = clr_reg + CN_AW'(1);
            end
            OP_UL_RD: cp_raddr = p_reg;
            OP_UL_CHK: begin
                up_next  = cp_q_reg;
                cn_raddr = CN_AW'(p_reg);
                if (cp_q_reg < LINK_NIL) begin
                    cp_we    = 1'b1;
                    cp_waddr = p_reg;
                    cp_wdata = LINK_NIL;
                end
            end
            OP_UL_WUP: begin
                dn_next  = cn_q_reg;
                cn_we    = 1'b1;
                cn_waddr = up_reg[CN_AW-1:0];
                cn_wdata = cn_q_reg;
            end
            OP_UL_WP: begin
                cn_we    = 1'b1;
                cn_waddr = CN_AW'(p_reg);
                cn_wdata = LINK_NIL;
                if (dn_reg < HEAD_BASE) begin
                    cp_we    = 1'b1;
                    cp_waddr = dn_reg[POS_W-1:0];
                    cp_wdata = up_reg;
                end
            end
            OP_ADV_WR: begin
                ring_we    = 1'b1;
                ring_waddr = old_reg;
                ring_wdata = data_reg;
                old_next   = old_reg + POS_W'(1);
                if (flag_reg) p_next   = cur_reg;
                else          cur_next = cur_reg + POS_W'(1);
            end
            // four hash bytes plus four more for run detection
            OP_HS0: begin
                ra_addr = p_reg;
                rb_addr = p_reg + POS_W'(1);
            end
            OP_HS1: begin
                b_next[0] = ra_reg;
                b_next[1] = rb_reg;
                ra_addr   = p_reg + POS_W'(2);
                rb_addr   = p_reg + POS_W'(3);
            end
            OP_HS2: begin
                b_next[2] = ra_reg;
                b_next[3] = rb_reg;
                ra_addr   = p_reg + POS_W'(4);
                rb_addr   = p_reg + POS_W'(5);
            end
            OP_HS3: begin
                b_next[4] = ra_reg;
                b_next[5] = rb_reg;
                ra_addr   = p_reg + POS_W'(6);
                rb_addr   = p_reg + POS_W'(7);
            end
            OP_HS4: begin
                b_next[6] = ra_reg;
                b_next[7] = rb_reg;
                head_next = HEAD_BASE + LINK_W'(hash4(b_reg[0], b_reg[1], b_reg[2], b_reg[3]));
            end
            OP_LK_RD: cn_raddr = head_reg[CN_AW-1:0];
            OP_LK_W1: begin
                dn_next  = cn_q_reg;
                cn_we    = 1'b1;
                cn_waddr = head_reg[CN_AW-1:0];
                cn_wdata = LINK_W'(p_reg);
                cp_we    = 1'b1;
                cp_waddr = p_reg;
                cp_wdata = head_reg;
            end
            OP_LK_W2: begin
                cn_we    = 1'b1;
                cn_waddr = CN_AW'(p_reg);
                cn_wdata = dn_reg;
                if (dn_reg < HEAD_BASE) begin
                    cp_we    = 1'b1;
                    cp_waddr = dn_reg[POS_W-1:0];
                    cp_wdata = LINK_W'(p_reg);
                end
                cur_next = cur_reg + POS_W'(1);
            end
            OP_SR_INIT: begin
                node_next     = head_reg;
                best_len_next = '0;
                best_ofs_next = '0;
            end
            OP_SR_RD: cn_raddr = node_reg[CN_AW-1:0];
            OP_SR_NEXT: begin
                node_next = cn_q_reg;
                k_next    = '0;
            end
            OP_CMP_RD: begin
                ra_addr = node_reg[POS_W-1:0] + POS_W'(k_reg);
                rb_addr = cur_reg + POS_W'(k_reg);
            end
            OP_CMP_EQ: if (eq_ab) k_next = k1[7:0];
            OP_EVAL: begin
                if (ev_take) begin
                    best_ofs_next = ofs;
                    best_len_next = ev_len;
                    p_next        = node_reg[POS_W-1:0];
                end
            end
            OP_RN_START: begin
                pmax_next = pmax_c;
                pmin_next = pmin_c;
                rp_next   = 9'({pmax_c, 1'b0});
                n_next    = 3'd4;
            end
            OP_RN_N: begin
                j_next = '0;
                if (!stat.rn_go) n_next = n_reg - 3'd1;
            end
            OP_RN_RD: ra_addr = cur_reg + POS_W'(rp_reg) + POS_W'(j_reg);
            OP_RN_CMP: begin
                if (!rn_eq)                    n_next  = n_reg - 3'd1;
                else if (j_reg == 2'(n_reg - 3'd1)) rp_next = rp_reg + 9'(n_reg);
                else                           j_next  = j_reg + 2'd1;
            end
            OP_RN_FIN: begin
                if (pmin_reg == 3'd0) begin
                    rlen_next = '0;
                    rper_next = 3'd1;
                    rcnt_next = '0;
                end else begin
                    rlen_next = rlen_c;
                    rper_next = pmin_reg;
                    rcnt_next = run_div(rlen_c, pmin_reg);
                end
            end
            OP_OUT: begin
                if (stat.out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, rcnt_reg, rper_reg, rlen_reg,
                                    12'(best_ofs_reg), best_len_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= POS_W'(WINDOW - int'(EFF_RST));
            old_reg     <= '0;
            prime_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            old_reg     <= old_next;
            prime_reg   <= prime_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        up_reg       <= up_next;
        dn_reg       <= dn_next;
        node_reg     <= node_next;
        head_reg     <= head_next;
        data_reg     <= data_next;
        flag_reg     <= flag_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        best_len_reg <= best_len_next;
        best_ofs_reg <= best_ofs_next;
        pmax_reg     <= pmax_next;
        pmin_reg     <= pmin_next;
        n_reg        <= n_next;
        j_reg        <= j_next;
        rp_reg       <= rp_next;
        rlen_reg     <= rlen_next;
        rper_reg     <= rper_next;
        rcnt_reg     <= rcnt_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

### hw/rtl/lzss_hash_chain_match_finder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzss_hash_chain_match_finder
// LZSS match finder over a 4096-byte history ring with 14-bit hash chains.
// ----------------------------------------------------------------------------
// Usage:
//  s_ channel: one command word per transfer, tuser = cmd (clear, prime,
//  advance, search), tdata = data byte and link flag. m_ channel: one result
//  word per search (match length/offset and repeat run).
//  The block works one word at a time; s_tready is high only while idle.
//  Advance unlinks the oldest position if it is still linked and writes the
//  byte into the ring; with the link flag set it then hashes and links the
//  current position. Search hashes the lookahead, walks its chain comparing
//  each candidate byte by byte, then detects a repeat run; each chain memory
//  has a single read port and the compare runs byte-serial.
//  A full-length match also unlinks the matched position.
//  Reset and the clear command run a clearing pass over the chain memories,
//  during which no word is taken; max_len writes still land.
//  The result sits in an output register: while the receiver stalls, new
//  commands are still taken, and only the next search waits at its end.
//  max_len is APB register 0 (byte address 0), reset 255.
// ----------------------------------------------------------------------------
module lzss_hash_chain_match_finder
    import lzhc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] register_flag
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [7:0] match_len, [19:8] match_offset,
                                        // [27:20] run_len, [30:28] run_period,
                                        // [38:31] run_count
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_MAX_LEN = 1'b0;

    logic [7:0] max_len_reg, max_len_next;
    logic [7:0] eff;
    logic       reg_hit;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_MAX_LEN);
    assign prdata  = reg_hit ? {24'd0, max_len_reg} : 32'd0;

    always_comb begin
        max_len_next = max_len_reg;
        if (psel && penable && pwrite && pready && reg_hit) max_len_next = pwdata[7:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) max_len_reg <= 8'd255;
        else          max_len_reg <= max_len_next;
    end

    assign eff = eff_len(max_len_reg);

    lzhc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_cmd   (cmd_t'(s_tuser)),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lzhc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_cmd  (cmd_t'(s_tuser)),
        .in_byte (s_tdata[7:0]),
        .in_flag (s_tdata[8]),
        .eff     (eff),
        .stat    (stat),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata)
    );

    // a reported match is at least 4 bytes back
    a_match_ofs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:0] != 8'd0) |-> (m_tdata[19:8] >= 12'd4))
        else $error("match with offset below 4");

    a_run_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:28] >= 3'd1 && m_tdata[30:28] <= 3'd4))
        else $error("run period out of range");

    a_match_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] <= eff && m_tdata[27:20] <= eff))
        else $error("length beyond max_len");

endmodule
`default_nettype wire

### test/tb_lzss_hash_chain_match_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzss_hash_chain_match_finder
// Self-checking bench for the LZSS hash-chain match finder. A scoreboard
// tracks ring, chains and pointers, predicts each search word and compares it
// field by field. The lookahead is primed after reset and a few hundred bytes
// are advanced in, then directed words and random phases run under several
// max_len settings with random stalls; each new max_len starts with a clear.
// ----------------------------------------------------------------------------
module tb_lzss_hash_chain_match_finder;
    import lzhc_pkg::*;

    class match_scoreboard;
        bit [7:0]   ring[WINDOW];
        int         cnext[CN_DEPTH];
        int         cprev[WINDOW];
        int         cur_pos;
        int         old_pos;
        int         primed;
        bit [7:0]   max_len;
        int         errors;
        int         searches;
        int         match_hits;
        int         runs;
        bit [39:0]  expected_q[$];

        function int eff();
            int v;
            v = max_len;
            if (v < 4) v = 4;
            if (v > MAX_LEN_LIMIT) v = MAX_LEN_LIMIT;
            if (WINDOW < 2 * v) v = WINDOW / 2 - 1;
            return v;
        endfunction

        function int at(int base, int k);
            return ring[(base + k) % WINDOW];
        endfunction

        function int hash(int p);
            int h;
            h = at(p, 0) ^ (at(p, 1) << 2) ^ (at(p, 2) << 4) ^ (at(p, 3) << 6);
            return h & (HEAD_COUNT - 1);
        endfunction

        function void unlink(int p);
            int up;
            int dn;
            up = cprev[p];
            if (up >= CN_DEPTH) return;
            cprev[p] = CN_DEPTH;
            dn = cnext[p];
            cnext[up] = dn;
            cnext[p] = CN_DEPTH;
            if (dn < WINDOW) cprev[dn] = up;
        endfunction

        function void link(int p);
            int head;
            int old;
            unlink(p);
            head = WINDOW + hash(p);
            old = cnext[head];
            cnext[head] = p;
            cprev[p] = head;
            cnext[p] = old;
            if (old < WINDOW) cprev[old] = p;
        endfunction

        function void clear_tables();
            foreach (cnext[i]) cnext[i] = CN_DEPTH;
            foreach (cprev[i]) cprev[i] = CN_DEPTH;
            cur_pos = WINDOW - eff();
            old_pos = 0;
            primed = 0;
        endfunction

        function void reset();
            max_len = 8'd255;
            foreach (ring[i]) ring[i] = 8'd0;
            clear_tables();
        endfunction

        function bit [39:0] search();
            int ref_p, lim, node, nx, best_len, best_ofs, steps, len, ofs, k;
            int pmax, pmin, p, n;
            bit same;
            bit go;
            bit [39:0] w;
            ref_p = cur_pos;
            lim = eff();
            node = WINDOW + hash(ref_p);
            best_len = 0;
            best_ofs = 0;
            steps = 0;
            while (steps < WINDOW) begin
                nx = cnext[node];
                if (nx >= WINDOW) break;
                node = nx;
                steps++;
                if (node == ref_p) continue;
                same = 1;
                for (k = 0; k < 4; k++)
                    if (at(node, k) != at(ref_p, k)) same = 0;
                if (!same) continue;
                len = 4;
                while (len < lim && at(node, len) == at(ref_p, len)) len++;
                if (len <= best_len) continue;
                ofs = (ref_p > node) ? ref_p - node : WINDOW + ref_p - node;
                if (ofs < 4) continue;
                if (ofs <= len) begin
                    if (ofs <= best_len) continue;
                    len = ofs;
                end
                best_ofs = ofs;
                best_len = len;
                if (best_len >= lim) begin
                    unlink(node);
                    best_len = lim;
                    break;
                end
            end
            // repeat run: largest agreeing period sets the start, smallest is reported
            if (lim > RUN_MAX) lim = RUN_MAX;
            pmax = 0;
            pmin = 0;
            for (n = 4; n >= 1; n--) begin
                same = 1;
                for (k = 0; k < n; k++)
                    if (at(ref_p, k) != at(ref_p, n + k)) same = 0;
                if (same) begin
                    if (pmax == 0) pmax = n;
                    pmin = n;
                end
            end
            w = '0;
            w[7:0] = best_len[7:0];
            w[19:8] = best_ofs[11:0];
            w[30:28] = 3'd1;
            if (pmin != 0) begin
                p = 2 * pmax;
                for (n = 4; n >= 1; n--) begin
                    go = (n == 3) ? (pmax == 3 && pmin == 3) : (pmax >= n && pmin <= n);
                    if (!go) continue;
                    while (p + n <= lim) begin
                        same = 1;
                        for (k = 0; k < n; k++)
                            if (at(ref_p, k) != at(ref_p, p + k)) same = 0;
                        if (!same) break;
                        p += n;
                    end
                end
                if (p > lim) p = lim;
                w[27:20] = p[7:0];
                w[30:28] = pmin[2:0];
                w[38:31] = 8'(p / pmin);
                runs++;
            end
            if (best_len != 0) match_hits++;
            return w;
        endfunction

        function void note_word(cmd_t cmd, bit [7:0] data, bit flag);
            case (cmd)
                CMD_CLEAR: begin
                    clear_tables();
                end
                CMD_PRIME: begin
                    if (primed < eff()) begin
                        ring[(cur_pos + primed) % WINDOW] = data;
                        primed++;
                    end
                end
                CMD_ADVANCE: begin
                    unlink(old_pos);
                    ring[old_pos] = data;
                    old_pos = (old_pos + 1) % WINDOW;
                    if (flag) link(cur_pos);
                    cur_pos = (cur_pos + 1) % WINDOW;
                end
                default: begin
                    expected_q.push_back(search());
                    searches++;
                end
            endcase
        endfunction

        function void check_result(bit [39:0] got);
            bit [39:0] exp_w;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            if (got[7:0] !== exp_w[7:0]) begin
                $error("match_len exp %0d got %0d", exp_w[7:0], got[7:0]);
                errors++;
            end
            if (got[19:8] !== exp_w[19:8]) begin
                $error("match_offset exp %0d got %0d", exp_w[19:8], got[19:8]);
                errors++;
            end
            if (got[27:20] !== exp_w[27:20]) begin
                $error("run_len exp %0d got %0d", exp_w[27:20], got[27:20]);
                errors++;
            end
            if (got[30:28] !== exp_w[30:28]) begin
                $error("run_period exp %0d got %0d", exp_w[30:28], got[30:28]);
                errors++;
            end
            if (got[38:31] !== exp_w[38:31]) begin
                $error("run_count exp %0d got %0d", exp_w[38:31], got[38:31]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    match_scoreboard sb = new();
    bit  quiet = 1'b1;             // no idling on either side while set
    int  rx_wait = 0;
    int  words_sent = 0;

    always #1 aclk = ~aclk;

    lzss_hash_chain_match_finder i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready && !quiet) rx_wait <= $urandom_range(0, 5);
            end
        end
    end

    task automatic send_word(cmd_t cmd, bit [7:0] data, bit flag);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, flag, data};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(cmd, data, flag);
        words_sent++;
    endtask

    // only called with the block idle
    task automatic write_max_len(bit [7:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'd0;
        pwdata <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.max_len = value;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);   // room for the longest advance, one with link
    endtask

    function automatic bit [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return sb.ring[(sb.old_pos + WINDOW - $urandom_range(1, 40)) % WINDOW];
        if (r < 5) return sb.ring[(sb.old_pos + WINDOW - 1) % WINDOW];
        if (r < 8) begin
            case ($urandom_range(0, 3))
                0: return 8'h00;
                1: return 8'hFF;
                2: return 8'hA5;
                default: return 8'h5A;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 399);
            if (r == 0) begin
                send_word(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (r < 20) begin
                send_word(CMD_PRIME, pick_byte(), 1'($urandom_range(0, 1)));
            end else if (r < 120) begin
                send_word(CMD_SEARCH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_word(CMD_ADVANCE, pick_byte(), $urandom_range(0, 6) != 0);
            end
        end
        send_word(CMD_SEARCH, 8'h00, 1'b0);    // also waits out any clearing pass
        drain();
    endtask

    initial begin
        bit [7:0] settings[4];
        sb.reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // prime the whole lookahead and write the start of the ring, so that
        // every later lookahead lies on written bytes
        for (int i = 0; i < EFF_RST; i++)
            send_word(CMD_PRIME, 8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 300; i++)
            send_word(CMD_ADVANCE, 8'($urandom_range(0, 255)), 1'b0);

        // directed words
        quiet = 1'b0;
        send_word(CMD_SEARCH, 8'h00, 1'b0);
        send_word(CMD_ADVANCE, 8'hFF, 1'b1);
        send_word(CMD_ADVANCE, 8'h00, 1'b0);
        send_word(CMD_PRIME, 8'hFF, 1'b1);
        for (int i = 0; i < 12; i++) send_word(CMD_ADVANCE, 8'(8'h11 * (i % 5 + 1)), 1'b1);
        send_word(CMD_SEARCH, 8'hFF, 1'b1);
        send_word(CMD_SEARCH, 8'h00, 1'b0);
        send_word(CMD_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < 3; i++) send_word(CMD_PRIME, 8'hAA, 1'b0);
        send_word(CMD_SEARCH, 8'h00, 1'b0);
        drain();

        settings[0] = 8'd4;
        settings[1] = 8'd0;
        settings[2] = 8'($urandom_range(5, 254));
        settings[3] = 8'd255;
        random_phase(70);
        foreach (settings[i]) begin
            write_max_len(settings[i]);
            // new pointer spacing for the new lookahead length
            send_word(CMD_CLEAR, 8'h00, 1'b0);
            random_phase(70);
        end

        $display("words sent: %0d, searches checked: %0d", words_sent, sb.searches);
        $display("searches with a match: %0d, with a repeat run: %0d", sb.match_hits, sb.runs);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### lzss_hash_chain_match_finder.f
hw/rtl/lzhc_pkg.sv
hw/rtl/lzhc_ctrl.sv
hw/rtl/lzhc_dp.sv
hw/rtl/lzss_hash_chain_match_finder.sv
test/tb_lzss_hash_chain_match_finder.sv
